// ----- rtl/fno_pkg.sv -----
// fno_pkg: shared types, constants and step functions for the facet normal block
`default_nettype none
package fno_pkg;

  localparam int SQ_STAGES = 16;              // two root bits per stage
  localparam int DV_STAGES = 8;               // two quotient bits per stage
  localparam logic [15:0] UNIT_ONE = 16'd16384;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  // what travels beside the normalisation arithmetic
  typedef struct packed {
    vec3_t            va;
    vec3_t            vb;
    vec3_t            vc;
    logic [2:0]       neg;
    logic [2:0][30:0] amag;
  } carry_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    logic [2:0][47:0] rem;
    logic [2:0][15:0] q;
  } dv_t;

  // one bit of the digit-by-digit integer square root
  function automatic sq_t sqrt_step(sq_t s, int i);
    logic [63:0] b;
    sq_t o;
    b = 64'd1 << (62 - 2 * i);
    o = s;
    if (s.x >= s.res + b) begin
      o.x   = s.x - (s.res + b);
      o.res = (s.res >> 1) + b;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // one quotient bit of the restoring divide, for all three lanes
  function automatic dv_t div_step(dv_t d, logic [31:0] len, int k);
    logic [47:0] trial;
    dv_t o;
    trial = {16'd0, len} << k;
    o = d;
    for (int l = 0; l < 3; l++) begin
      if (d.rem[l] >= trial) begin
        o.rem[l]    = d.rem[l] - trial;
        o.q[l][k]   = 1'b1;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fno_if.sv -----
// fno_if: facet input and result channel interfaces
`default_nettype none
interface fno_in_if import fno_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t v0_x, v0_y, v0_z;
  coord_t v1_x, v1_y, v1_z;
  coord_t v2_x, v2_y, v2_z;
  coord_t hint_x, hint_y, hint_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  hint_x, hint_y, hint_z, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                hint_x, hint_y, hint_z, output ready);
endinterface

interface fno_out_if import fno_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_a_x, out_a_y, out_a_z;
  coord_t out_b_x, out_b_y, out_b_z;
  coord_t out_c_x, out_c_y, out_c_z;
  coord_t unit_x, unit_y, unit_z;

  modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                  out_c_x, out_c_y, out_c_z, unit_x, unit_y, unit_z, input ready);
  modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                out_c_x, out_c_y, out_c_z, unit_x, unit_y, unit_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/facet_normal_orient_top.sv -----
// facet_normal_orient_top: facet orientation and unit normal pipeline
//
//  channel    dir  contents
//  in_tri     in   v0, v1, v2 vertices and stored normal hint
//  out_tri    out  reordered vertices a, b, c and Q1.14 unit normal
//  cfg_*      in   use_file_normal enable, written when cfg_we is high
//
// one transaction enters per cycle while the pipe is not frozen; the latency is set
// mainly by the 16 root stages and 8 divide stages (two bits each) of the normalisation.
// all stages advance together; when the output register holds an untaken
// transaction the whole pipe freezes and in_tri.ready drops.
// reset clears the stage valid bits and sets use_file_normal to 1.
`default_nettype none
module facet_normal_orient_top import fno_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  fno_in_if.sink    in_tri,
  fno_out_if.source out_tri
);

  localparam int SQ_BASE = 7;                        // valid bit of the sum stage
  localparam int DV_BASE = SQ_BASE + SQ_STAGES + 1;  // valid bit of the numerator stage
  localparam int LAT     = DV_BASE + DV_STAGES + 2;

  logic           use_file_normal_r;
  logic [LAT-1:0] pipe_vld_r;
  logic           en;

  assign en           = !pipe_vld_r[LAT-1] || out_tri.ready;
  assign in_tri.ready = en;
  assign out_tri.valid = pipe_vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_file_normal_r <= 1'b1;
      pipe_vld_r        <= '0;
    end else begin
      if (cfg_we) use_file_normal_r <= cfg_wdata;
      if (en) pipe_vld_r <= {pipe_vld_r[LAT-2:0], in_tri.valid};
    end
  end

  // stage 1: edge vectors
  logic signed [16:0] s1_u_r [3];
  logic signed [16:0] s1_w_r [3];
  vec3_t              s1_v0_r, s1_v1_r, s1_v2_r, s1_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u_r[0] <= 17'(in_tri.v1_x) - 17'(in_tri.v0_x);
      s1_u_r[1] <= 17'(in_tri.v1_y) - 17'(in_tri.v0_y);
      s1_u_r[2] <= 17'(in_tri.v1_z) - 17'(in_tri.v0_z);
      s1_w_r[0] <= 17'(in_tri.v2_x) - 17'(in_tri.v0_x);
      s1_w_r[1] <= 17'(in_tri.v2_y) - 17'(in_tri.v0_y);
      s1_w_r[2] <= 17'(in_tri.v2_z) - 17'(in_tri.v0_z);
      s1_v0_r   <= '{x: in_tri.v0_x, y: in_tri.v0_y, z: in_tri.v0_z};
      s1_v1_r   <= '{x: in_tri.v1_x, y: in_tri.v1_y, z: in_tri.v1_z};
      s1_v2_r   <= '{x: in_tri.v2_x, y: in_tri.v2_y, z: in_tri.v2_z};
      s1_h_r    <= '{x: in_tri.hint_x, y: in_tri.hint_y, z: in_tri.hint_z};
    end
  end

  // stage 2: cross product terms
  logic signed [33:0] s2_p_r [6];
  vec3_t              s2_v0_r, s2_v1_r, s2_v2_r, s2_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r[0] <= s1_u_r[1] * s1_w_r[2];
      s2_p_r[1] <= s1_u_r[2] * s1_w_r[1];
      s2_p_r[2] <= s1_u_r[2] * s1_w_r[0];
      s2_p_r[3] <= s1_u_r[0] * s1_w_r[2];
      s2_p_r[4] <= s1_u_r[0] * s1_w_r[1];
      s2_p_r[5] <= s1_u_r[1] * s1_w_r[0];
      s2_v0_r   <= s1_v0_r;
      s2_v1_r   <= s1_v1_r;
      s2_v2_r   <= s1_v2_r;
      s2_h_r    <= s1_h_r;
    end
  end

  // stage 3: normal
  logic signed [34:0] s3_n_r [3];
  vec3_t              s3_v0_r, s3_v1_r, s3_v2_r, s3_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n_r[0] <= 35'(s2_p_r[0]) - 35'(s2_p_r[1]);
      s3_n_r[1] <= 35'(s2_p_r[2]) - 35'(s2_p_r[3]);
      s3_n_r[2] <= 35'(s2_p_r[4]) - 35'(s2_p_r[5]);
      s3_v0_r   <= s2_v0_r;
      s3_v1_r   <= s2_v1_r;
      s3_v2_r   <= s2_v2_r;
      s3_h_r    <= s2_h_r;
    end
  end

  // stage 4: dot product terms and normal magnitudes
  logic signed [50:0] s4_d_r [3];
  logic        [33:0] s4_mag_r [3];
  logic        [2:0]  s4_neg_r;
  vec3_t              s4_v0_r, s4_v1_r, s4_v2_r;
  logic        [34:0] s3_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_abs[i] = s3_n_r[i][34] ? 35'(-s3_n_r[i]) : 35'(s3_n_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_d_r[0] <= s3_h_r.x * s3_n_r[0];
      s4_d_r[1] <= s3_h_r.y * s3_n_r[1];
      s4_d_r[2] <= s3_h_r.z * s3_n_r[2];
      for (int i = 0; i < 3; i++) begin
        s4_mag_r[i] <= s3_abs[i][33:0];
        s4_neg_r[i] <= s3_n_r[i][34];
      end
      s4_v0_r <= s3_v0_r;
      s4_v1_r <= s3_v1_r;
      s4_v2_r <= s3_v2_r;
    end
  end

  // stage 5: orientation decision and largest component
  logic signed [52:0] s4_dot;
  logic               s4_swap;
  logic        [33:0] s4_max;
  logic        [2:0]  s4_sneg;

  always_comb begin
    s4_dot  = 53'(s4_d_r[0]) + 53'(s4_d_r[1]) + 53'(s4_d_r[2]);
    s4_swap = use_file_normal_r && s4_dot[52];
    s4_max  = s4_mag_r[0];
    if (s4_mag_r[1] > s4_max) s4_max = s4_mag_r[1];
    if (s4_mag_r[2] > s4_max) s4_max = s4_mag_r[2];
    for (int i = 0; i < 3; i++) begin
      // negating a zero component keeps it non-negative
      s4_sneg[i] = s4_swap ? (!s4_neg_r[i] && (s4_mag_r[i] != '0)) : s4_neg_r[i];
    end
  end

  logic        [33:0] s5_mag_r [3];
  logic        [33:0] s5_max_r;
  logic        [2:0]  s5_neg_r;
  vec3_t              s5_va_r, s5_vb_r, s5_vc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_mag_r <= s4_mag_r;
      s5_max_r <= s4_max;
      s5_neg_r <= s4_sneg;
      s5_va_r  <= s4_swap ? s4_v2_r : s4_v0_r;
      s5_vb_r  <= s4_v1_r;
      s5_vc_r  <= s4_swap ? s4_v0_r : s4_v2_r;
    end
  end

  // stage 6: scale down so every component fits 31 bits
  logic [1:0]  s5_sh;
  logic [33:0] s5_scaled [3];
  carry_t      s6_car_r;

  always_comb begin
    priority if (s5_max_r[33]) s5_sh = 2'd3;
    else if (s5_max_r[32])     s5_sh = 2'd2;
    else if (s5_max_r[31])     s5_sh = 2'd1;
    else                       s5_sh = 2'd0;
    for (int i = 0; i < 3; i++) s5_scaled[i] = s5_mag_r[i] >> s5_sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_car_r.va  <= s5_va_r;
      s6_car_r.vb  <= s5_vb_r;
      s6_car_r.vc  <= s5_vc_r;
      s6_car_r.neg <= s5_neg_r;
      for (int i = 0; i < 3; i++) s6_car_r.amag[i] <= s5_scaled[i][30:0];
    end
  end

  // stage 7: squares
  logic [61:0] s7_sq_r [3];
  carry_t      s7_car_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq_r[i] <= 62'(s6_car_r.amag[i]) * 62'(s6_car_r.amag[i]);
      end
      s7_car_r <= s6_car_r;
    end
  end

  // sum of squares, then the root stages
  sq_t    sq_r     [SQ_STAGES+1];
  carry_t sq_car_r [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].x     <= 64'(s7_sq_r[0]) + 64'(s7_sq_r[1]) + 64'(s7_sq_r[2]);
      sq_r[0].res   <= '0;
      sq_car_r[0]   <= s7_car_r;
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g+1]     <= sqrt_step(sqrt_step(sq_r[g], 2 * g), 2 * g + 1);
        sq_car_r[g+1] <= sq_car_r[g];
      end
    end
  end

  // numerator with half the length for rounding, then the divide stages
  dv_t         dv_r     [DV_STAGES+1];
  logic [31:0] dv_len_r [DV_STAGES+1];
  carry_t      dv_car_r [DV_STAGES+1];
  logic [31:0] sq_len;

  assign sq_len = sq_r[SQ_STAGES].res[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= {3'd0, sq_car_r[SQ_STAGES].amag[i], 14'd0} + {17'd0, sq_len[31:1]};
      end
      dv_r[0].q   <= '0;
      dv_len_r[0] <= sq_len;
      dv_car_r[0] <= sq_car_r[SQ_STAGES];
    end
  end

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g+1] <= div_step(div_step(dv_r[g], dv_len_r[g], 15 - 2 * g), dv_len_r[g],
                              14 - 2 * g);
        dv_len_r[g+1] <= dv_len_r[g];
        dv_car_r[g+1] <= dv_car_r[g];
      end
    end
  end

  // output register: clamp, zero for a degenerate facet, apply sign
  logic   [15:0] fin_mag [3];
  coord_t        fin_unit [3];
  carry_t        fin_car;
  coord_t        unit_r [3];
  vec3_t         va_r, vb_r, vc_r;

  assign fin_car = dv_car_r[DV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_mag[i] = (dv_r[DV_STAGES].q[i] > UNIT_ONE) ? UNIT_ONE : dv_r[DV_STAGES].q[i];
      if (dv_len_r[DV_STAGES] == '0) fin_mag[i] = '0;
      fin_unit[i] = fin_car.neg[i] ? coord_t'(-fin_mag[i]) : coord_t'(fin_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= fin_unit;
      va_r   <= fin_car.va;
      vb_r   <= fin_car.vb;
      vc_r   <= fin_car.vc;
    end
  end

  assign out_tri.out_a_x = va_r.x;
  assign out_tri.out_a_y = va_r.y;
  assign out_tri.out_a_z = va_r.z;
  assign out_tri.out_b_x = vb_r.x;
  assign out_tri.out_b_y = vb_r.y;
  assign out_tri.out_b_z = vb_r.z;
  assign out_tri.out_c_x = vc_r.x;
  assign out_tri.out_c_y = vc_r.y;
  assign out_tri.out_c_z = vc_r.z;
  assign out_tri.unit_x  = unit_r[0];
  assign out_tri.unit_y  = unit_r[1];
  assign out_tri.unit_z  = unit_r[2];

`ifndef SYNTHESIS
  // the root of a sum of three squares below 2^62 fits 32 bits
  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r[SQ_BASE + SQ_STAGES] |-> sq_r[SQ_STAGES].res[63:32] == '0)
    else $error("square root wider than 32 bits");

  // each component is at most the length, so no quotient passes one
  // a zero length is degenerate and its quotient is discarded
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_vld_r[DV_BASE + DV_STAGES] && dv_len_r[DV_STAGES] != '0) |->
      dv_r[DV_STAGES].q[0] <= UNIT_ONE && dv_r[DV_STAGES].q[1] <= UNIT_ONE &&
      dv_r[DV_STAGES].q[2] <= UNIT_ONE)
    else $error("normal quotient above one");

  // a stalled output freezes the whole pipe
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tri.valid && !out_tri.ready) |=> $stable(pipe_vld_r) && $stable(dv_r[0].rem))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire
